FILE: sv/matrix_multiply_4x4_core_defines.svh
`ifndef MATRIX_MULTIPLY_4X4_CORE_DEFINES_SVH
`define MATRIX_MULTIPLY_4X4_CORE_DEFINES_SVH

// clocked check, masked while reset is active
`define MM4_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mm4 check failed");

// clocked check that also holds during reset
`define MM4_ASSERT_RST(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("mm4 reset check failed");

`endif

FILE: sv/mm4_pkg.sv
package mm4_pkg;

    localparam int LANES       = 4;
    localparam int LANE_W      = 2;
    localparam int SLOT_W      = 3;
    localparam int ELEM_W      = 32;
    localparam int PROD_W      = 64;
    localparam int DIM_DEFAULT = 4;

    typedef logic [LANES-1:0][ELEM_W-1:0] vec_t;

    typedef struct packed {
        logic              wr;
        logic              is_b;
        logic [LANE_W-1:0] idx;
        vec_t              elem;
        logic              go;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_OUT
    } state_t;

endpackage

FILE: sv/mm4_load_if.sv
interface mm4_load_if;
    logic                              valid;
    logic                              ready;
    logic [mm4_pkg::SLOT_W-1:0]        slot;
    logic signed [mm4_pkg::ELEM_W-1:0] elem0;
    logic signed [mm4_pkg::ELEM_W-1:0] elem1;
    logic signed [mm4_pkg::ELEM_W-1:0] elem2;
    logic signed [mm4_pkg::ELEM_W-1:0] elem3;
    logic                              go;

    modport source (output valid, slot, elem0, elem1, elem2, elem3, go, input ready);
    modport sink (input valid, slot, elem0, elem1, elem2, elem3, go, output ready);
endinterface

FILE: sv/mm4_result_if.sv
interface mm4_result_if;
    logic                              valid;
    logic                              ready;
    logic [mm4_pkg::LANE_W-1:0]        column;
    logic signed [mm4_pkg::PROD_W-1:0] prod0;
    logic signed [mm4_pkg::PROD_W-1:0] prod1;
    logic signed [mm4_pkg::PROD_W-1:0] prod2;
    logic signed [mm4_pkg::PROD_W-1:0] prod3;
    logic                              final_res;

    modport source (output valid, column, prod0, prod1, prod2, prod3, final_res, input ready);
    modport sink (input valid, column, prod0, prod1, prod2, prod3, final_res, output ready);
endinterface

FILE: sv/mm4_front.sv
module mm4_front #(
    parameter int DIM = mm4_pkg::DIM_DEFAULT
) (
    mm4_load_if.sink         load,
    output logic             push_valid,
    input  logic             push_ready,
    output mm4_pkg::cmd_t    push_cmd
);

    localparam int USED = (DIM < mm4_pkg::LANES) ? DIM : mm4_pkg::LANES;

    logic [mm4_pkg::LANE_W-1:0] idx;

    assign idx = load.slot[mm4_pkg::LANE_W-1:0];

    always_comb
    begin
        push_cmd.idx     = idx;
        push_cmd.is_b    = load.slot[mm4_pkg::SLOT_W-1];
        // rows or columns past the used size are dropped
        push_cmd.wr      = ({1'b0, idx} < (mm4_pkg::LANE_W+1)'(USED));
        push_cmd.elem[0] = load.elem0;
        push_cmd.elem[1] = load.elem1;
        push_cmd.elem[2] = load.elem2;
        push_cmd.elem[3] = load.elem3;
        push_cmd.go      = load.go;
    end

    assign push_valid = load.valid;
    assign load.ready = push_ready;

endmodule

FILE: sv/mm4_queue.sv
module mm4_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  mm4_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output mm4_pkg::cmd_t pop_cmd
);

    mm4_pkg::cmd_t head_reg, head_next;
    mm4_pkg::cmd_t spare_reg, spare_next;
    logic          head_vld_reg, head_vld_next;
    logic          spare_vld_reg, spare_vld_next;
    logic          push;
    logic          pop;

    assign push_ready = !spare_vld_reg;
    assign pop_valid  = head_vld_reg;
    assign pop_cmd    = head_reg;
    assign push       = push_valid && push_ready;
    assign pop        = head_vld_reg && pop_ready;

    always_comb
    begin
        head_next      = head_reg;
        spare_next     = spare_reg;
        head_vld_next  = head_vld_reg;
        spare_vld_next = spare_vld_reg;
        if (pop)
        begin
            if (spare_vld_reg)
            begin
                head_next      = spare_reg;
                spare_vld_next = 1'b0;
            end
            else if (push)
            begin
                head_next = push_cmd;
            end
            else
            begin
                head_vld_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!head_vld_reg)
            begin
                head_next     = push_cmd;
                head_vld_next = 1'b1;
            end
            else
            begin
                spare_next     = push_cmd;
                spare_vld_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg  <= 1'b0;
            spare_vld_reg <= 1'b0;
        end
        else
        begin
            head_vld_reg  <= head_vld_next;
            spare_vld_reg <= spare_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg  <= head_next;
        spare_reg <= spare_next;
    end

endmodule

FILE: sv/mm4_back.sv
module mm4_back #(
    parameter int DIM = mm4_pkg::DIM_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  mm4_pkg::cmd_t pop_cmd,
    mm4_result_if.source  result
);

    localparam int USED = (DIM < mm4_pkg::LANES) ? DIM : mm4_pkg::LANES;
    localparam logic [mm4_pkg::LANE_W-1:0] LAST = mm4_pkg::LANE_W'(USED - 1);
    localparam logic [mm4_pkg::LANE_W-1:0] ONE  = mm4_pkg::LANE_W'(1);

    mm4_pkg::state_t state_reg, state_next;
    logic [mm4_pkg::LANE_W-1:0] k_reg, k_next;
    logic [mm4_pkg::LANE_W-1:0] c_reg, c_next;
    logic mul_vld_reg, mul_vld_next;
    logic mul_first_reg, mul_first_next;
    logic pop;

    mm4_pkg::vec_t a_row_reg [mm4_pkg::LANES];
    mm4_pkg::vec_t b_col_reg [mm4_pkg::LANES];

    logic signed [mm4_pkg::ELEM_W-1:0] a_el [mm4_pkg::LANES];
    logic signed [mm4_pkg::ELEM_W-1:0] b_el;
    logic signed [mm4_pkg::PROD_W-1:0] mul_full [mm4_pkg::LANES];
    logic signed [mm4_pkg::PROD_W-1:0] prod_reg [mm4_pkg::LANES];
    logic signed [mm4_pkg::PROD_W-1:0] acc_reg [mm4_pkg::LANES];
    logic signed [mm4_pkg::PROD_W-1:0] out_prod [mm4_pkg::LANES];

    function automatic logic signed [mm4_pkg::PROD_W-1:0] sat_add(
        input logic signed [mm4_pkg::PROD_W-1:0] x,
        input logic signed [mm4_pkg::PROD_W-1:0] y
    );
        logic signed [mm4_pkg::PROD_W:0] s;
        s = {x[mm4_pkg::PROD_W-1], x} + {y[mm4_pkg::PROD_W-1], y};
        if (s[mm4_pkg::PROD_W] != s[mm4_pkg::PROD_W-1])
        begin
            if (s[mm4_pkg::PROD_W])
                return {1'b1, {(mm4_pkg::PROD_W-1){1'b0}}};
            else
                return {1'b0, {(mm4_pkg::PROD_W-1){1'b1}}};
        end
        return s[mm4_pkg::PROD_W-1:0];
    endfunction

    assign pop = pop_valid && pop_ready;

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        c_next         = c_reg;
        mul_vld_next   = 1'b0;
        mul_first_next = 1'b0;
        pop_ready      = 1'b0;
        case (state_reg)
            mm4_pkg::ST_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid && pop_cmd.go)
                begin
                    state_next = mm4_pkg::ST_MUL;
                    k_next     = '0;
                    c_next     = '0;
                end
            end
            mm4_pkg::ST_MUL:
            begin
                mul_vld_next   = 1'b1;
                mul_first_next = (k_reg == '0);
                k_next         = k_reg + ONE;
                if (k_reg == LAST)
                begin
                    k_next     = '0;
                    state_next = mm4_pkg::ST_ACC;
                end
            end
            mm4_pkg::ST_ACC:
            begin
                state_next = mm4_pkg::ST_OUT;
            end
            mm4_pkg::ST_OUT:
            begin
                if (result.ready)
                begin
                    if (c_reg == LAST)
                    begin
                        state_next = mm4_pkg::ST_IDLE;
                    end
                    else
                    begin
                        c_next     = c_reg + ONE;
                        state_next = mm4_pkg::ST_MUL;
                    end
                end
            end
            default:
            begin
                state_next = mm4_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mm4_pkg::ST_IDLE;
            k_reg         <= '0;
            c_reg         <= '0;
            mul_vld_reg   <= 1'b0;
            mul_first_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            c_reg         <= c_next;
            mul_vld_reg   <= mul_vld_next;
            mul_first_reg <= mul_first_next;
        end
    end

    // row and column stores
    always_ff @(posedge clk)
    begin
        if (pop && pop_cmd.wr)
        begin
            if (pop_cmd.is_b)
                b_col_reg[pop_cmd.idx] <= pop_cmd.elem;
            else
                a_row_reg[pop_cmd.idx] <= pop_cmd.elem;
        end
    end

    // one lane per row of C
    always_comb
    begin
        b_el = b_col_reg[c_reg][k_reg];
        for (int r = 0; r < mm4_pkg::LANES; r++)
        begin
            a_el[r]     = a_row_reg[r][k_reg];
            mul_full[r] = a_el[r] * b_el;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < mm4_pkg::LANES; r++)
        begin
            if (state_reg == mm4_pkg::ST_MUL)
                prod_reg[r] <= mul_full[r];
            if (mul_vld_reg)
                acc_reg[r] <= sat_add(mul_first_reg ? '0 : acc_reg[r], prod_reg[r]);
        end
    end

    always_comb
    begin
        for (int r = 0; r < mm4_pkg::LANES; r++)
            out_prod[r] = (r < USED) ? acc_reg[r] : '0;
    end

    assign result.valid     = (state_reg == mm4_pkg::ST_OUT);
    assign result.column    = c_reg;
    assign result.prod0     = out_prod[0];
    assign result.prod1     = out_prod[1];
    assign result.prod2     = out_prod[2];
    assign result.prod3     = out_prod[3];
    assign result.final_res = (c_reg == LAST);

endmodule

FILE: sv/matrix_multiply_4x4_core.sv
// 4x4 signed fixed-point matrix multiply, C = A * B. Load items carry a row of A
// (slot 0-3) or a column of B (slot 4-7) as four Q16.16 elements; loads enter a
// two-item queue and are taken at one per cycle while the compute side is idle.
// An item with go set is stored and then starts a run that returns one item per
// column of C, column 0 first, each with four Q32.32 dot products summed in element
// order with saturation after every add; the last column has final_res set.
// With N as DIM capped at four, four multiplier lanes, one per row of C, step
// through the N elements of each dot product one per cycle, then the ACC state
// finishes the accumulate and the OUT state presents the column until taken.
// Loads keep filling the queue while a run is active. With DIM below four only
// the first DIM rows, columns and elements are used and unused products read as
// zero. Reading a store entry that was never loaded gives undefined data.
module matrix_multiply_4x4_core #(
    parameter int DIM = mm4_pkg::DIM_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    mm4_load_if.sink     load,
    mm4_result_if.source result
);

    logic          push_valid;
    logic          push_ready;
    mm4_pkg::cmd_t push_cmd;
    logic          pop_valid;
    logic          pop_ready;
    mm4_pkg::cmd_t pop_cmd;

    mm4_front #(
        .DIM (DIM)
    ) u_front (
        .load       (load),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    mm4_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    mm4_back #(
        .DIM (DIM)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .result    (result)
    );

endmodule

FILE: sv/mm4_checker.sv
`include "matrix_multiply_4x4_core_defines.svh"

module mm4_checker #(
    parameter int DIM = mm4_pkg::DIM_DEFAULT
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              result_valid,
    input logic                              result_ready,
    input logic [mm4_pkg::LANE_W-1:0]        result_column,
    input logic signed [mm4_pkg::PROD_W-1:0] result_prod0,
    input logic signed [mm4_pkg::PROD_W-1:0] result_prod3,
    input logic                              result_final_res
);

    localparam int USED = (DIM < mm4_pkg::LANES) ? DIM : mm4_pkg::LANES;
    localparam logic [mm4_pkg::LANE_W-1:0] LAST = mm4_pkg::LANE_W'(USED - 1);
    localparam logic [mm4_pkg::LANE_W-1:0] ONE  = mm4_pkg::LANE_W'(1);

    logic [mm4_pkg::LANE_W-1:0] exp_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            exp_col_reg <= '0;
        else if (result_valid && result_ready)
            exp_col_reg <= result_final_res ? '0 : result_column + ONE;
    end

    `MM4_ASSERT_RST(a_no_result_in_reset, !rst_n |-> !result_valid)
    `MM4_ASSERT(a_result_held, result_valid && !result_ready |=> result_valid && $stable(result_column) && $stable(result_prod0) && $stable(result_prod3))
    `MM4_ASSERT(a_column_order, result_valid |-> result_column == exp_col_reg)
    `MM4_ASSERT(a_final_on_last, result_valid |-> result_final_res == (result_column == LAST))

endmodule

bind matrix_multiply_4x4_core mm4_checker #(
    .DIM (DIM)
) u_mm4_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .result_column    (result.column),
    .result_prod0     (result.prod0),
    .result_prod3     (result.prod3),
    .result_final_res (result.final_res)
);
